// ----- hw/rtl/mspm_pkg.sv -----
// Shared widths, reset values, register codes and control structs of the peak meter.
`timescale 1ns / 1ps

package mspm_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int CH_W             = 4;
  localparam int LEVEL_W          = 15;
  localparam int COUNT_W          = 5;
  localparam int DECAY_W          = 15;
  localparam int CFG_DATA_W       = 15;
  localparam int PROD_W           = LEVEL_W + DECAY_W;
  localparam int DEF_MAX_CHANNELS = 16;

  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);
  localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(27525);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef enum logic [0:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_DECAY_FACTOR  = 1'b1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic update;
    logic scan_init;
    logic scan_rd;
    logic peak_clear;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } dp_sts_t;

  // Magnitude of a Q1.15 sample; the most negative code saturates to full scale.
  function automatic logic [LEVEL_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    begin
      neg = SAMPLE_W'(-s);
      if (!s[SAMPLE_W-1]) begin
        abs_sat = s[LEVEL_W-1:0];
      end else if (neg[SAMPLE_W-1]) begin
        abs_sat = LEVEL_MAX;
      end else begin
        abs_sat = neg[LEVEL_W-1:0];
      end
    end
  endfunction

endpackage

// ----- hw/rtl/mspm_if.sv -----
// Request channel interfaces of the peak meter: sample input, level output, configuration.
`timescale 1ns / 1ps

interface mspm_in_if import mspm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CH_W-1:0]            channel;
  logic                       block_end;

  modport source (output valid, output sample, output channel, output block_end, input ready);
  modport sink (input valid, input sample, input channel, input block_end, output ready);
endinterface

interface mspm_out_if import mspm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;

  modport source (output valid, output left_level, output right_level, input ready);
  modport sink (input valid, input left_level, input right_level, output ready);
endinterface

interface mspm_cfg_if import mspm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/mspm_dp.sv -----
// Datapath of the peak meter: configuration, peak memory, top-two scan and level smoothing.
`timescale 1ns / 1ps

module mspm_dp import mspm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NW           = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [CH_W-1:0]            in_channel,
  input  logic                       in_block_end,
  mspm_cfg_if.sink                   cfg_if,
  mspm_out_if.source                 out_if,
  input  dp_cmd_t                    cmd,
  input  logic [AW-1:0]              scan_addr,
  output dp_sts_t                    sts,
  output logic [NW-1:0]              meter_count
);

  localparam int CW = (AW > CH_W) ? AW : CH_W;

  logic [COUNT_W-1:0] count_r;
  logic [DECAY_W-1:0] decay_r;

  logic [LEVEL_W-1:0]      peak_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] peak_vld_r;
  logic [LEVEL_W-1:0]      rd_data_r;
  logic                    rd_vld_r;

  logic [LEVEL_W-1:0] mag_r;
  logic [AW-1:0]      addr_r;
  logic               hit_r;
  logic               last_r;

  logic               scan_pend_r;
  logic [AW-1:0]      scan_idx_r;
  logic [LEVEL_W-1:0] best_r, second_r, p0_r, p1_r;

  logic [LEVEL_W-1:0] lp_r, rp_r;
  logic [PROD_W-1:0]  lprod_r, rprod_r;
  logic [LEVEL_W-1:0] left_store_r, right_store_r;
  logic               out_valid_r;

  logic [CW-1:0]      ch_w;
  logic [AW-1:0]      ch_addr;
  logic               in_range;
  logic [AW-1:0]      rd_addr;
  logic [LEVEL_W-1:0] old_peak, upd_peak, scan_peak;
  logic [LEVEL_W-1:0] lp, rp, ldec, rdec;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RST;
      decay_r <= DECAY_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CHANNEL_COUNT: count_r <= cfg_if.data[COUNT_W-1:0];
        REG_DECAY_FACTOR:  decay_r <= cfg_if.data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective channel count: at least one, at most the number of peak entries.
  always_comb begin
    if (count_r == '0) begin
      meter_count = NW'(1);
    end else if (32'(count_r) > MAX_CHANNELS) begin
      meter_count = NW'(MAX_CHANNELS);
    end else begin
      meter_count = NW'(count_r);
    end
  end

  assign ch_w     = CW'(in_channel);
  assign ch_addr  = ch_w[AW-1:0];
  assign in_range = 32'(in_channel) < 32'(meter_count);
  assign rd_addr  = cmd.load_item ? ch_addr : scan_addr;

  // Peak memory; an entry whose valid bit is clear reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.load_item || cmd.scan_rd) begin
      rd_data_r <= peak_mem[rd_addr];
    end
    if (cmd.update && hit_r) begin
      peak_mem[addr_r] <= upd_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (cmd.load_item || cmd.scan_rd) begin
        rd_vld_r <= peak_vld_r[rd_addr];
      end
      if (cmd.peak_clear) begin
        peak_vld_r <= '0;
      end else if (cmd.update && hit_r) begin
        peak_vld_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      last_r <= 1'b0;
    end else if (cmd.load_item) begin
      hit_r  <= in_range;
      last_r <= in_block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mag_r  <= abs_sat(in_sample);
      addr_r <= ch_addr;
    end
  end

  assign old_peak  = rd_vld_r ? rd_data_r : '0;
  assign upd_peak  = (old_peak < mag_r) ? mag_r : old_peak;
  assign scan_peak = old_peak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pend_r <= 1'b0;
    end else begin
      scan_pend_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      scan_idx_r <= scan_addr;
    end
    if (cmd.scan_init) begin
      best_r   <= '0;
      second_r <= '0;
      p0_r     <= '0;
      p1_r     <= '0;
    end else if (scan_pend_r) begin
      if (scan_peak > best_r) begin
        second_r <= best_r;
        best_r   <= scan_peak;
      end else if (scan_peak > second_r) begin
        second_r <= scan_peak;
      end
      if (scan_idx_r == AW'(0)) begin
        p0_r <= scan_peak;
      end
      if (scan_idx_r == AW'(1)) begin
        p1_r <= scan_peak;
      end
    end
  end

  always_comb begin
    if (meter_count == NW'(1)) begin
      lp = p0_r;
      rp = p0_r;
    end else if (meter_count == NW'(2)) begin
      lp = p0_r;
      rp = p1_r;
    end else begin
      lp = best_r;
      rp = (second_r != '0) ? second_r : best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      lp_r    <= lp;
      rp_r    <= rp;
      lprod_r <= PROD_W'(left_store_r) * PROD_W'(decay_r);
      rprod_r <= PROD_W'(right_store_r) * PROD_W'(decay_r);
    end
  end

  assign ldec = lprod_r[PROD_W-1:DECAY_W];
  assign rdec = rprod_r[PROD_W-1:DECAY_W];

  // The stored levels double as the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_store_r  <= '0;
      right_store_r <= '0;
      out_valid_r   <= 1'b0;
    end else if (cmd.out_load) begin
      left_store_r  <= (lp_r > ldec) ? lp_r : ldec;
      right_store_r <= (rp_r > rdec) ? rp_r : rdec;
      out_valid_r   <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r   <= 1'b0;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.left_level  = left_store_r;
  assign out_if.right_level = right_store_r;

  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_if.ready;

endmodule

// ----- hw/rtl/mspm_ctrl.sv -----
// Controller of the peak meter: sequences sample update, peak scan and level output.
`timescale 1ns / 1ps

module mspm_ctrl import mspm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NW           = $clog2(MAX_CHANNELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dp_sts_t       sts,
  input  logic [NW-1:0] meter_count,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] scan_addr
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UPDATE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_SMOOTH = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic          scan_done;

  assign scan_done = (NW'(scan_r) + NW'(1)) == meter_count;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        scan_nxt  = '0;
        state_nxt = sts.last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        scan_nxt = scan_r + AW'(1);
        if (scan_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SMOOTH;
      ST_SMOOTH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign scan_addr      = scan_r;
  assign cmd.load_item  = (state_r == ST_IDLE) && in_valid;
  assign cmd.update     = (state_r == ST_UPDATE);
  assign cmd.scan_init  = (state_r == ST_UPDATE) && sts.last;
  assign cmd.scan_rd    = (state_r == ST_SCAN);
  assign cmd.peak_clear = (state_r == ST_DRAIN);
  assign cmd.mul        = (state_r == ST_MUL);
  assign cmd.out_load   = (state_r == ST_SMOOTH) && sts.out_free;

endmodule

// ----- hw/rtl/multichannel_stereo_peak_meter.sv -----
// Top level of the multichannel stereo peak meter: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel   Direction  Carries
// in_if     sink       sample (Q1.15), channel index, block_end flag
// out_if    source     left_level, right_level (Q0.15)
// cfg_if    sink       register index, write data; always ready
//
// A sample that does not end a block is accepted in ST_IDLE, where its channel's peak is
// read, and its new peak is written back in ST_UPDATE. A block-ending sample then passes
// the peak scan, which reads the peak memory through its one read port one entry per
// cycle for the N metered channels, then the drain, multiply and final steps; the final
// step waits while the previous result is still held on out_if. Reset is synchronous, active low;
// it clears the peak valid bits, the stored levels and restores the register defaults.

module multichannel_stereo_peak_meter import mspm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  mspm_in_if.sink    in_if,
  mspm_out_if.source out_if,
  mspm_cfg_if.sink   cfg_if
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW = $clog2(MAX_CHANNELS + 1);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] scan_addr;
  logic [NW-1:0] meter_count;
  logic          in_ready;

  assign in_if.ready = in_ready;

  // The controller only sequences; all values live in the datapath.
  mspm_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .NW           (NW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_ready),
    .sts         (sts),
    .meter_count (meter_count),
    .cmd         (cmd),
    .scan_addr   (scan_addr)
  );

  // The datapath holds the configuration, the per-channel peaks and the levels.
  mspm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW),
    .NW           (NW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sample    (in_if.sample),
    .in_channel   (in_if.channel),
    .in_block_end (in_if.block_end),
    .cfg_if       (cfg_if),
    .out_if       (out_if),
    .cmd          (cmd),
    .scan_addr    (scan_addr),
    .sts          (sts),
    .meter_count  (meter_count)
  );

  // An accepted request holds off the next one while its peak is written back.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted during peak write-back");

  // A request that does not end a block frees the input once its peak is written back.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && !in_if.block_end) |-> ##2 in_if.ready)
    else $error("non-final request did not release the input in time");

  // A new result never overwrites one still waiting on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_if.valid || out_if.ready))
    else $error("pending result overwritten");

endmodule
